[rtl/core/bdm_pkg.sv]
`default_nettype none

package bdm_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_COUNT = 3;

	localparam int SIZE_W  = 13;
	localparam int THR_W   = 8;
	localparam int SPAN_W  = 9;
	localparam int PIX_W   = 8;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int SLOT_W  = 2;
	localparam int REG_W   = ADDR_W - 2;

	localparam int FIFO_DEPTH = 4;

	localparam logic [REG_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [REG_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [REG_W-1:0] REG_DIFF_THRESHOLD = 2'd2;
	localparam logic [REG_W-1:0] REG_WINDOW_SPAN    = 2'd3;

	localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST    = 13'd640;
	localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
	localparam logic [THR_W-1:0]  DIFF_THRESHOLD_RST = 8'd6;
	localparam logic [SPAN_W-1:0] WINDOW_SPAN_RST    = 9'd50;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [PIX_W-1:0] MASK_CLEAN   = 8'd255;
	localparam logic [PIX_W-1:0] MASK_BLEMISH = 8'd0;

	localparam int ROLE_LEFT  = 0;
	localparam int ROLE_RIGHT = 1;
	localparam int ROLE_CTR   = 2;
	localparam int ROLE_COUNT = 3;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [PIX_W-1:0]  pix_t;

	typedef struct packed {
		logic blemish;
		logic frame_last;
	} res_t;

	function automatic slot_t slot_next(slot_t s);
		return (s == slot_t'(LINE_COUNT - 1)) ? slot_t'(0) : slot_t'(s + 1'b1);
	endfunction

	function automatic slot_t slot_prev(slot_t s);
		return (s == slot_t'(0)) ? slot_t'(LINE_COUNT - 1) : slot_t'(s - 1'b1);
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		pix_t lo;
		pix_t hi;
		pix_t m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

endpackage

`default_nettype wire

[rtl/core/bdm_ram.sv]
`default_nettype none

module bdm_ram #(
	parameter int WIDTH = bdm_pkg::PIX_W,
	parameter int DEPTH = bdm_pkg::MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[rtl/core/blemish_detect_median_window.sv]
// Blemish detector on an 8-bit grey raster stream.
// Item channel (item_valid/item_ready): opcode 0 carries the next raster pixel,
// opcode 1 is a flush tick; flush ticks before the frame is complete are dropped,
// pixels after it act as flush ticks. Result channel (result_valid/result_ready)
// gives mask_value, blemish and frame_last for one pixel of the frame.
// The result for a pixel comes with the item that arrives width+half items
// after it, so width+half flush ticks drain the end of a frame.
// Throughput: one item per clock while item_ready is high. Each pixel item does one
// line store write and every item three column reads (left, right, centre); every read
// column has its own copy of the three-row store, nine 8-bit x MAX_WIDTH banks in all.
// Path: two pipeline stages (read, decision) and then the result queue from item to result.
// Stall: up to four results queue at the output; item_ready falls while four
// results are outstanding and rises as soon as one is taken.
// Reset: registers return to 640 x 480, threshold 6, span 50; all counters clear.
// The line store is not cleared and needs no clearing pass.
// Configuration over APB at byte addresses 0, 4, 8, 12; pready is always high.
`default_nettype none

module blemish_detect_median_window #(
	parameter int MAX_WIDTH  = bdm_pkg::MAX_WIDTH,
	parameter int MAX_HEIGHT = bdm_pkg::MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bdm_pkg::ADDR_W-1:0]   paddr,
	input  logic [bdm_pkg::DATA_W-1:0]   pwdata,
	output logic [bdm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,

	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         opcode,
	input  logic [bdm_pkg::PIX_W-1:0]    pixel,

	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [bdm_pkg::PIX_W-1:0]    mask_value,
	output logic                         blemish,
	output logic                         frame_last
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int HALF_W = bdm_pkg::SPAN_W - 1;
	localparam int LW     = $clog2(MAX_WIDTH + (1 << HALF_W));
	localparam int AW     = ((WW > HALF_W) ? WW : HALF_W) + 1;
	localparam int SW     = (WW > HW) ? WW : HW;
	localparam int EW     = ((bdm_pkg::SIZE_W > SW) ? bdm_pkg::SIZE_W : SW) + 1;
	localparam int RXW    = HW + 1;
	localparam int PW     = $clog2(bdm_pkg::FIFO_DEPTH);
	localparam int FCW    = $clog2(bdm_pkg::FIFO_DEPTH + 1);

	localparam int NR = bdm_pkg::ROLE_COUNT;
	localparam int NS = bdm_pkg::LINE_COUNT;

	logic [bdm_pkg::SIZE_W-1:0] width_q;
	logic [bdm_pkg::SIZE_W-1:0] height_q;
	logic [bdm_pkg::THR_W-1:0]  thr_q;
	logic [bdm_pkg::SPAN_W-1:0] span_q;

	logic                      cfg_wr;
	logic [bdm_pkg::REG_W-1:0] reg_idx;

	logic [EW-1:0]     wx;
	logic [EW-1:0]     hx;
	logic [WW-1:0]     eff_w;
	logic [HW-1:0]     eff_h;
	logic [HALF_W-1:0] half;
	logic [LW-1:0]     lag;

	logic [CW-1:0]         in_col_q;
	logic [HW-1:0]         in_row_q;
	bdm_pkg::slot_t        in_slot_q;
	logic [CW-1:0]         out_col_q;
	logic [RW-1:0]         out_row_q;
	bdm_pkg::slot_t        out_slot_q;
	logic [LW-1:0]         lag_q;

	logic          accept;
	logic          complete;
	logic          drop;
	logic          wen;
	logic          active;
	logic          waiting;
	logic          emit;
	logic          row_end;
	logic          col_end;
	logic          row_last;
	logic          row_edge;
	logic          last;
	logic [AW-1:0] right_sum;
	logic [AW-1:0] w_m1;
	logic [CW-1:0] left_col;
	logic [CW-1:0] right_col;

	logic [CW-1:0]       rd_col  [NR];
	bdm_pkg::pix_t       rd_data [NR][NS];
	logic [NR-1:0]       fwd;

	logic                valid_s1;
	logic [NR-1:0]       fwd_s1;
	bdm_pkg::slot_t      wslot_s1;
	bdm_pkg::pix_t       wdata_s1;
	bdm_pkg::slot_t      slot_s1;
	logic                edge_s1;
	logic                last_s1;

	bdm_pkg::pix_t       val [NR][NS];
	bdm_pkg::pix_t       lv;
	bdm_pkg::pix_t       rv;
	bdm_pkg::pix_t       ctr;

	logic                valid_s2;
	bdm_pkg::pix_t       lv_s2;
	bdm_pkg::pix_t       rv_s2;
	bdm_pkg::pix_t       ctr_s2;
	logic                last_s2;

	logic [bdm_pkg::PIX_W:0] pair_sum;
	bdm_pkg::pix_t           avg;
	bdm_pkg::pix_t           dev;
	bdm_pkg::res_t           res_new;

	bdm_pkg::res_t  fifo_q [bdm_pkg::FIFO_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [FCW-1:0] fcnt_q;
	logic [FCW-1:0] credit_q;
	logic           pop;
	bdm_pkg::res_t  head;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[bdm_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bdm_pkg::IMAGE_WIDTH_RST;
			height_q <= bdm_pkg::IMAGE_HEIGHT_RST;
			thr_q    <= bdm_pkg::DIFF_THRESHOLD_RST;
			span_q   <= bdm_pkg::WINDOW_SPAN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bdm_pkg::REG_IMAGE_WIDTH:    width_q  <= pwdata[bdm_pkg::SIZE_W-1:0];
				bdm_pkg::REG_IMAGE_HEIGHT:   height_q <= pwdata[bdm_pkg::SIZE_W-1:0];
				bdm_pkg::REG_DIFF_THRESHOLD: thr_q    <= pwdata[bdm_pkg::THR_W-1:0];
				bdm_pkg::REG_WINDOW_SPAN:    span_q   <= pwdata[bdm_pkg::SPAN_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bdm_pkg::REG_IMAGE_WIDTH:    prdata = bdm_pkg::DATA_W'(width_q);
			bdm_pkg::REG_IMAGE_HEIGHT:   prdata = bdm_pkg::DATA_W'(height_q);
			bdm_pkg::REG_DIFF_THRESHOLD: prdata = bdm_pkg::DATA_W'(thr_q);
			bdm_pkg::REG_WINDOW_SPAN:    prdata = bdm_pkg::DATA_W'(span_q);
		endcase
	end

	// effective frame size
	assign wx = EW'(width_q);
	assign hx = EW'(height_q);

	always_comb begin
		if (wx == '0) begin
			eff_w = WW'(1);
		end else if (wx > EW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(wx);
		end
		if (hx == '0) begin
			eff_h = HW'(1);
		end else if (hx > EW'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(hx);
		end
	end

	assign half = span_q[bdm_pkg::SPAN_W-1:1];
	assign lag  = LW'(eff_w) + LW'(half);

	// item stage
	assign accept   = item_valid && item_ready;
	assign complete = RXW'(in_row_q) >= RXW'(eff_h);
	assign drop     = !complete && (opcode == bdm_pkg::OP_FLUSH);
	assign wen      = accept && !complete && (opcode == bdm_pkg::OP_PIXEL);
	assign active   = accept && !drop;
	assign waiting  = lag_q < lag;
	assign emit     = active && !waiting;

	assign row_end  = (AW'(in_col_q) + AW'(1)) >= AW'(eff_w);
	assign col_end  = (AW'(out_col_q) + AW'(1)) >= AW'(eff_w);
	assign row_last = (RXW'(out_row_q) + RXW'(1)) >= RXW'(eff_h);
	assign row_edge = (out_row_q == '0) || row_last;
	assign last     = row_last && col_end;

	assign right_sum = AW'(out_col_q) + AW'(half);
	assign w_m1      = AW'(eff_w) - AW'(1);
	assign right_col = (right_sum > w_m1) ? CW'(w_m1) : CW'(right_sum);
	assign left_col  = (AW'(out_col_q) > AW'(half)) ? CW'(AW'(out_col_q) - AW'(half)) : '0;

	assign rd_col[bdm_pkg::ROLE_LEFT]  = left_col;
	assign rd_col[bdm_pkg::ROLE_RIGHT] = right_col;
	assign rd_col[bdm_pkg::ROLE_CTR]   = out_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			lag_q      <= '0;
		end else if (active) begin
			if (wen) begin
				if (row_end) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= bdm_pkg::slot_next(in_slot_q);
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (waiting) begin
				lag_q <= lag_q + 1'b1;
			end else if (last) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
				lag_q      <= '0;
			end else if (col_end) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + 1'b1;
				out_slot_q <= bdm_pkg::slot_next(out_slot_q);
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	// line store: one copy per read column, one bank per row slot
	for (genvar k = 0; k < NR; k++) begin : g_role
		assign fwd[k] = wen && (in_col_q == rd_col[k]);
		for (genvar j = 0; j < NS; j++) begin : g_slot
			bdm_ram #(
				.WIDTH (bdm_pkg::PIX_W),
				.DEPTH (MAX_WIDTH)
			) u_ram (
				.clk     (clk),
				.wr_en   (wen && (in_slot_q == bdm_pkg::slot_t'(j))),
				.wr_addr (in_col_q),
				.wr_data (pixel),
				.rd_addr (rd_col[k]),
				.rd_data (rd_data[k][j])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		fwd_s1   <= fwd;
		wslot_s1 <= in_slot_q;
		wdata_s1 <= pixel;
		slot_s1  <= out_slot_q;
		edge_s1  <= row_edge;
		last_s1  <= last;
	end

	// read stage: patch in the same item's write, then medians
	always_comb begin
		for (int k = 0; k < NR; k++) begin
			for (int j = 0; j < NS; j++) begin
				val[k][j] = (fwd_s1[k] && (wslot_s1 == bdm_pkg::slot_t'(j))) ?
					wdata_s1 : rd_data[k][j];
			end
		end
		if (edge_s1) begin
			lv = val[bdm_pkg::ROLE_LEFT][slot_s1];
			rv = val[bdm_pkg::ROLE_RIGHT][slot_s1];
		end else begin
			lv = bdm_pkg::med3(val[bdm_pkg::ROLE_LEFT][bdm_pkg::slot_prev(slot_s1)],
				val[bdm_pkg::ROLE_LEFT][slot_s1],
				val[bdm_pkg::ROLE_LEFT][bdm_pkg::slot_next(slot_s1)]);
			rv = bdm_pkg::med3(val[bdm_pkg::ROLE_RIGHT][bdm_pkg::slot_prev(slot_s1)],
				val[bdm_pkg::ROLE_RIGHT][slot_s1],
				val[bdm_pkg::ROLE_RIGHT][bdm_pkg::slot_next(slot_s1)]);
		end
		ctr = val[bdm_pkg::ROLE_CTR][slot_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		lv_s2   <= lv;
		rv_s2   <= rv;
		ctr_s2  <= ctr;
		last_s2 <= last_s1;
	end

	// decision stage
	assign pair_sum = (bdm_pkg::PIX_W + 1)'(lv_s2) + (bdm_pkg::PIX_W + 1)'(rv_s2);
	assign avg      = pair_sum[bdm_pkg::PIX_W:1];
	assign dev      = (avg > ctr_s2) ? (avg - ctr_s2) : (ctr_s2 - avg);

	assign res_new.blemish    = dev > thr_q;
	assign res_new.frame_last = last_s2;

	// result queue
	assign pop        = result_valid && result_ready;
	assign item_ready = credit_q != FCW'(bdm_pkg::FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			fifo_q[wptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			fcnt_q   <= '0;
			credit_q <= '0;
		end else begin
			if (valid_s2) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (valid_s2 && !pop) begin
				fcnt_q <= fcnt_q + 1'b1;
			end else if (!valid_s2 && pop) begin
				fcnt_q <= fcnt_q - 1'b1;
			end
			if (emit && !pop) begin
				credit_q <= credit_q + 1'b1;
			end else if (!emit && pop) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

	assign head         = fifo_q[rptr_q];
	assign result_valid = fcnt_q != '0;
	assign blemish      = head.blemish;
	assign frame_last   = head.frame_last;
	assign mask_value   = head.blemish ? bdm_pkg::MASK_BLEMISH : bdm_pkg::MASK_CLEAN;

endmodule

`default_nettype wire
